// File: rtl/svq_pkg.sv
package svq_pkg;
	localparam int MAX_EDGES_DEF = 64;
	localparam int COORD_BITS_DEF = 24;
	localparam int OFFSET_BITS = 16;
	localparam int ACTION_BITS = 2;
	localparam int STATUS_BITS = 2;
	localparam int HELD_BITS = 7;
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_RSVD = 2'd3;
	localparam logic [1:0] ST_STORED = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_VISIBLE = 2'd2;
	localparam logic [1:0] ST_BLOCKED = 2'd3;
	localparam int REG_BUFFER_OFFSET = 0;
endpackage

// File: rtl/svq_cross.sv
// Shared crossing unit. One multiply per cycle into registered products, then
// sign and magnitude compares. start pulses with operands held stable by caller.
module svq_cross #(
	parameter int CW = svq_pkg::COORD_BITS_DEF + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [CW-1:0] p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y,
	output logic                 done,
	output logic                 hit
);
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;
	logic [2:0] step_q;
	logic busy_q;
	logic signed [DW-1:0] ma, mb;
	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q;
	logic signed [SW-1:0] den, sn, tn, dn, sa, ta;
	logic signed [DW-1:0] d1x, d1y, d2x, d2y, ex, ey;
	logic pos;

	assign d1x = DW'(p2x) - DW'(p1x);
	assign d1y = DW'(p2y) - DW'(p1y);
	assign d2x = DW'(p4x) - DW'(p3x);
	assign d2y = DW'(p4y) - DW'(p3y);
	assign ex  = DW'(p1x) - DW'(p3x);
	assign ey  = DW'(p1y) - DW'(p3y);

	always_comb begin
		case (step_q)
			3'd0: begin ma = d1x; mb = d2y; end
			3'd1: begin ma = d2x; mb = d1y; end
			3'd2: begin ma = d1x; mb = ey; end
			3'd3: begin ma = d1y; mb = ex; end
			3'd4: begin ma = d2x; mb = ey; end
			3'd5: begin ma = d2y; mb = ex; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		case (step_q)
			3'd1: m0_q <= prod_s1;
			3'd2: m1_q <= prod_s1;
			3'd3: m2_q <= prod_s1;
			3'd4: m3_q <= prod_s1;
			3'd5: m4_q <= prod_s1;
			default: ;
		endcase
	end

	// final product arrives while step_q == 6
	assign den = SW'(m0_q) - SW'(m1_q);
	assign sn  = SW'(m2_q) - SW'(m3_q);
	assign tn  = SW'(m4_q) - SW'(prod_s1);
	assign pos = !den[SW-1];
	assign dn  = pos ? den : -den;
	assign sa  = pos ? sn : -sn;
	assign ta  = pos ? tn : -tn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			step_q <= 3'd1;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (step_q == 3'd6) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	assign done = busy_q && step_q == 3'd6;
	assign hit = (den != '0) && !sa[SW-1] && !ta[SW-1] && !((dn - sa) < 0)
		&& !((dn - ta) < 0);
endmodule

// File: rtl/segment_visibility_query_unit.sv
// Segment visibility query unit.
// Items enter on start when busy is low: action plus point and corner fields.
// Clear and append go from idle straight to the done state; the result strobes
// done with status and edges_held. A query walks the edge table twice through
// one shared crossing unit: a plain pass, then a buffered pass testing two
// offset copies of each edge not at a valid start or end corner. Each edge is
// first read from the table; each crossing test runs six multiplies on one
// multiplier, then one compare. A hit ends the query early. busy stays high
// until the result beat, which is shown for one cycle; the receiver cannot
// stall. buffer_offset is written through the APB port at address 0; the user
// must write it only while idle, as the block itself does not enforce this.
// Reset empties the table (count zero) and clears buffer_offset; table
// contents are not cleared.
module segment_visibility_query_unit #(
	parameter int MAX_EDGES = svq_pkg::MAX_EDGES_DEF,
	parameter int COORD_BITS = svq_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [1:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            action,
	input  logic signed [COORD_BITS-1:0] point_a_x, point_a_y, point_b_x, point_b_y,
	input  logic                  start_corner_valid,
	input  logic signed [COORD_BITS-1:0] start_corner_x, start_corner_y,
	input  logic                  end_corner_valid,
	input  logic signed [COORD_BITS-1:0] end_corner_x, end_corner_y,
	output logic                  done,
	output logic [1:0]            status,
	output logic [6:0]            edges_held
);
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NW = $clog2(MAX_EDGES + 1);
	localparam int CW = COORD_BITS + 2;
	localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_LOAD = 3'd2,
		S_WAIT = 3'd3, S_DONE = 3'd4;

	logic [2:0] st_q;
	logic [NW-1:0] total_q, idx_q;
	logic [15:0] off_q;
	logic pass_q, copy_q;
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, scx_q, scy_q, ecx_q, ecy_q;
	logic sv_q, ev_q;
	logic [4*COORD_BITS-1:0] mem [MAX_EDGES];
	logic [4*COORD_BITS-1:0] rd_q;
	logic signed [COORD_BITS-1:0] fx, fy, tx, ty;
	logic signed [CW-1:0] o, e3x, e3y, e4x, e4y;
	logic xstart, xdone, xhit, skip, last;
	logic [1:0] st_o_q;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'(svq_pkg::REG_BUFFER_OFFSET * 4)) ? {16'd0, off_q} : 32'd0;
	assign busy = st_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) off_q <= '0;
		else if (psel && penable && pwrite
			&& paddr == 2'(svq_pkg::REG_BUFFER_OFFSET * 4))
			off_q <= pwdata[15:0];
	end

	assign {fx, fy, tx, ty} = rd_q;
	assign o = CW'($signed({1'b0, off_q}));
	always_comb begin
		if (!pass_q) begin
			e3x = CW'(fx); e3y = CW'(fy); e4x = CW'(tx); e4y = CW'(ty);
		end else if (!copy_q) begin
			e3x = CW'(fx) - o; e3y = CW'(fy) - o; e4x = CW'(tx) + o; e4y = CW'(ty) + o;
		end else begin
			e3x = CW'(fx) + o; e3y = CW'(fy) + o; e4x = CW'(tx) - o; e4y = CW'(ty) - o;
		end
	end
	assign skip = pass_q && ((sv_q && ((fx == scx_q && fy == scy_q)
		|| (tx == scx_q && ty == scy_q))) || (ev_q && ((fx == ecx_q && fy == ecy_q)
		|| (tx == ecx_q && ty == ecy_q))));
	assign xstart = st_q == S_LOAD && !skip;
	assign last = idx_q + NW'(1) >= total_q;

	svq_cross #(.CW(CW)) u_cross (
		.clk(clk), .arst_n(arst_n), .start(xstart),
		.p1x(CW'(ax_q)), .p1y(CW'(ay_q)), .p2x(CW'(bx_q)), .p2y(CW'(by_q)),
		.p3x(e3x), .p3y(e3y), .p4x(e4x), .p4y(e4y),
		.done(xdone), .hit(xhit)
	);

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start && action == svq_pkg::ACT_APPEND
			&& total_q < NW'(MAX_EDGES))
			mem[total_q[AW-1:0]] <= {point_a_x, point_a_y, point_b_x, point_b_y};
		rd_q <= mem[idx_q[AW-1:0]];
		if (st_q == S_IDLE && start) begin
			ax_q <= point_a_x; ay_q <= point_a_y; bx_q <= point_b_x; by_q <= point_b_y;
			sv_q <= start_corner_valid; scx_q <= start_corner_x; scy_q <= start_corner_y;
			ev_q <= end_corner_valid; ecx_q <= end_corner_x; ecy_q <= end_corner_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; total_q <= '0; idx_q <= '0; pass_q <= 1'b0;
			copy_q <= 1'b0; st_o_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (start) begin
					idx_q <= '0; pass_q <= 1'b0; copy_q <= 1'b0;
					st_o_q <= svq_pkg::ST_STORED;
					st_q <= S_DONE;
					case (action)
						svq_pkg::ACT_CLEAR: total_q <= '0;
						svq_pkg::ACT_APPEND:
							if (total_q < NW'(MAX_EDGES)) total_q <= total_q + NW'(1);
							else st_o_q <= svq_pkg::ST_FULL;
						svq_pkg::ACT_QUERY: begin
							st_o_q <= svq_pkg::ST_VISIBLE;
							if (total_q != '0) st_q <= S_READ;
						end
						default: ;
					endcase
				end
				S_READ: st_q <= S_LOAD;
				S_LOAD: begin
					if (skip) begin
						if (last) st_q <= S_DONE;
						else begin idx_q <= idx_q + NW'(1); st_q <= S_READ; end
					end else st_q <= S_WAIT;
				end
				S_WAIT: if (xdone) begin
					if (xhit) begin
						st_o_q <= svq_pkg::ST_BLOCKED; st_q <= S_DONE;
					end else if (pass_q && !copy_q) begin
						copy_q <= 1'b1; st_q <= S_LOAD;
					end else if (!last) begin
						copy_q <= 1'b0; idx_q <= idx_q + NW'(1); st_q <= S_READ;
					end else if (!pass_q) begin
						pass_q <= 1'b1; idx_q <= '0; st_q <= S_READ;
					end else st_q <= S_DONE;
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign done = st_q == S_DONE;
	assign status = st_o_q;
	assign edges_held = 7'(total_q);
endmodule

// File: sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = svq_pkg::COORD_BITS_DEF;
	localparam int NMAX = svq_pkg::MAX_EDGES_DEF;
	localparam int WDOG_LIMIT = 60000;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		logic [1:0] act;
		coord_t ax, ay, bx, by;
		logic sv;
		coord_t scx, scy;
		logic ev;
		coord_t ecx, ecy;
	} item_t;

	typedef struct {
		logic [1:0] st;
		logic [6:0] held;
	} outcome_t;

	typedef struct {
		item_t it;
		logic known;
		logic [1:0] st;
		logic [6:0] held;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	item_t cur = '{default: '0};
	logic done;
	logic [1:0] status;
	logic [6:0] edges_held;

	// mirror of the edge table and offset register
	longint fx[NMAX], fy[NMAX], tx[NMAX], ty[NMAX];
	int n_edges = 0;
	longint offs = 0;

	outcome_t pending_q[$];
	outcome_t last_pred;
	row_t rows[$];
	int errors = 0;
	int beats_in = 0;
	int wdog = 0;
	int i, k, ph;

	always #6 clk = ~clk;

	segment_visibility_query_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .action(cur.act),
		.point_a_x(cur.ax), .point_a_y(cur.ay), .point_b_x(cur.bx), .point_b_y(cur.by),
		.start_corner_valid(cur.sv), .start_corner_x(cur.scx), .start_corner_y(cur.scy),
		.end_corner_valid(cur.ev), .end_corner_x(cur.ecx), .end_corner_y(cur.ecy),
		.done(done), .status(status), .edges_held(edges_held)
	);

	function automatic bit seg_cross(longint p1x, longint p1y, longint p2x, longint p2y,
			longint p3x, longint p3y, longint p4x, longint p4y);
		longint d1x, d1y, d2x, d2y, ex, ey, den, sn, tn;
		d1x = p2x - p1x; d1y = p2y - p1y;
		d2x = p4x - p3x; d2y = p4y - p3y;
		ex = p1x - p3x; ey = p1y - p3y;
		den = d1x * d2y - d2x * d1y;
		sn = d1x * ey - d1y * ex;
		tn = d2x * ey - d2y * ex;
		if (den == 0)
			return 0;
		if (den < 0) begin
			den = -den; sn = -sn; tn = -tn;
		end
		return sn >= 0 && sn <= den && tn >= 0 && tn <= den;
	endfunction

	function automatic bit has_point(int e, longint x, longint y);
		return (fx[e] == x && fy[e] == y) || (tx[e] == x && ty[e] == y);
	endfunction

	function automatic outcome_t visibility_step(item_t it);
		outcome_t r;
		bit blk;
		r.st = svq_pkg::ST_STORED;
		blk = 0;
		case (it.act)
			svq_pkg::ACT_CLEAR: n_edges = 0;
			svq_pkg::ACT_APPEND: begin
				if (n_edges < NMAX) begin
					fx[n_edges] = longint'(it.ax); fy[n_edges] = longint'(it.ay);
					tx[n_edges] = longint'(it.bx); ty[n_edges] = longint'(it.by);
					n_edges++;
				end else
					r.st = svq_pkg::ST_FULL;
			end
			svq_pkg::ACT_QUERY: begin
				for (int e = 0; e < n_edges && !blk; e++)
					if (seg_cross(it.ax, it.ay, it.bx, it.by, fx[e], fy[e], tx[e], ty[e]))
						blk = 1;
				for (int e = 0; e < n_edges && !blk; e++) begin
					if (it.sv && has_point(e, it.scx, it.scy))
						continue;
					if (it.ev && has_point(e, it.ecx, it.ecy))
						continue;
					if (seg_cross(it.ax, it.ay, it.bx, it.by,
							fx[e] - offs, fy[e] - offs, tx[e] + offs, ty[e] + offs) ||
						seg_cross(it.ax, it.ay, it.bx, it.by,
							fx[e] + offs, fy[e] + offs, tx[e] - offs, ty[e] - offs))
						blk = 1;
				end
				r.st = blk ? svq_pkg::ST_BLOCKED : svq_pkg::ST_VISIBLE;
			end
			default: ;
		endcase
		r.held = 7'(n_edges);
		return r;
	endfunction

	// acceptance and result checking, sampled at the rising edge
	always @(posedge clk) begin
		outcome_t want;
		if (done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result beat with nothing pending: status %0d held %0d",
					$time, status, edges_held);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					errors++;
				end
				if (edges_held !== want.held) begin
					$display("%0t: edges_held expected %0d actual %0d",
						$time, want.held, edges_held);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			last_pred = visibility_step(cur);
			pending_q.push_back(last_pred);
			beats_in++;
		end
		if ((arst_n && start && !busy) || done)
			wdog = 0;
		else
			wdog++;
		if (wdog >= WDOG_LIMIT) begin
			$display("segment_visibility_query_unit test failed");
			$finish;
		end
	end

	task automatic send(item_t it, int gap);
		int n;
		n = beats_in;
		@(negedge clk);
		cur = it;
		start = 1;
		while (beats_in == n)
			@(negedge clk);
		if (gap > 0) begin
			start = 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start = 0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_offset(logic [15:0] v);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0;
		paddr = 2'(svq_pkg::REG_BUFFER_OFFSET * 4);
		pwdata = {16'($urandom_range(65535)), v};
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		if (pready)
			offs = longint'(v);
		@(negedge clk);
		pwrite = 0; penable = 0;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		if (prdata !== {16'd0, v}) begin
			$display("%0t: buffer_offset readback expected %0h actual %0h",
				$time, {16'd0, v}, prdata);
			errors++;
		end
		@(negedge clk);
		psel = 0; penable = 0;
	endtask

	function automatic coord_t rnd_coord(bit wide);
		if (wide)
			return coord_t'($urandom);
		return coord_t'($signed($urandom_range(4096)) - 2048);
	endfunction

	function automatic item_t rnd_item(int mix);
		item_t it;
		int p, e;
		bit wide;
		wide = ($urandom_range(3) == 0);
		it.act = svq_pkg::ACT_QUERY;
		it.ax = rnd_coord(wide); it.ay = rnd_coord(wide);
		it.bx = rnd_coord(wide); it.by = rnd_coord(wide);
		it.sv = 1'($urandom_range(1)); it.ev = 1'($urandom_range(1));
		it.scx = rnd_coord(1); it.scy = rnd_coord(1);
		it.ecx = rnd_coord(1); it.ecy = rnd_coord(1);
		p = $urandom_range(99);
		if (p < 4)
			it.act = svq_pkg::ACT_CLEAR;
		else if (p < 6)
			it.act = svq_pkg::ACT_RSVD;
		else if (p < mix)
			it.act = svq_pkg::ACT_APPEND;
		// queries starting and ending next to stored corners
		if (it.act == svq_pkg::ACT_QUERY && n_edges > 0 && $urandom_range(1)) begin
			e = $urandom_range(n_edges - 1);
			it.scx = coord_t'(fx[e]); it.scy = coord_t'(fy[e]);
			it.ax = coord_t'(fx[e] + ($urandom_range(1) ? offs : -offs));
			it.ay = coord_t'(fy[e] + ($urandom_range(1) ? offs : -offs));
			e = $urandom_range(n_edges - 1);
			it.ecx = coord_t'(tx[e]); it.ecy = coord_t'(ty[e]);
			it.bx = coord_t'(tx[e] + ($urandom_range(1) ? offs : -offs));
			it.by = coord_t'(ty[e] + ($urandom_range(1) ? offs : -offs));
		end
		return it;
	endfunction

	function automatic row_t mk(logic [1:0] a, int ax, int ay, int bx, int by,
			bit sv, int scx, int scy, bit ev, int ecx, int ecy,
			bit known, logic [1:0] st, int held);
		row_t r;
		r.it = '{a, coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
			sv, coord_t'(scx), coord_t'(scy), ev, coord_t'(ecx), coord_t'(ecy)};
		r.known = known; r.st = st; r.held = 7'(held);
		return r;
	endfunction

	initial begin
		localparam int CMIN = -(1 << (CB - 1));
		localparam int CMAX = (1 << (CB - 1)) - 1;
		outcome_t tail;
		logic [15:0] offsets[4];

		rows.push_back(mk(svq_pkg::ACT_QUERY, 0, 0, 256, 256, 0, 0, 0, 0, 0, 0,
			1, svq_pkg::ST_VISIBLE, 0));
		rows.push_back(mk(svq_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, svq_pkg::ST_STORED, 0));
		rows.push_back(mk(svq_pkg::ACT_RSVD, CMAX, CMIN, CMAX, CMIN, 1, CMAX, CMAX, 1,
			CMIN, CMIN, 1, svq_pkg::ST_STORED, 0));
		rows.push_back(mk(svq_pkg::ACT_APPEND, CMIN, CMIN, CMAX, CMAX, 0, 0, 0, 0, 0, 0,
			1, svq_pkg::ST_STORED, 1));
		rows.push_back(mk(svq_pkg::ACT_APPEND, 0, 1024, 1024, 1024, 0, 0, 0, 0, 0, 0,
			1, svq_pkg::ST_STORED, 2));
		// crossing the long diagonal
		rows.push_back(mk(svq_pkg::ACT_QUERY, -512, 512, 512, -512, 0, 0, 0, 0, 0, 0,
			0, 0, 0));
		// parallel to the diagonal
		rows.push_back(mk(svq_pkg::ACT_QUERY, 0, 256, 256, 512, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// touching an endpoint of the horizontal edge
		rows.push_back(mk(svq_pkg::ACT_QUERY, 1024, 1024, 2048, 2048, 0, 0, 0, 0, 0, 0,
			0, 0, 0));
		rows.push_back(mk(svq_pkg::ACT_QUERY, 1024, 1100, 2048, 3000, 0, 0, 0, 0, 0, 0,
			0, 0, 0));
		rows.push_back(mk(svq_pkg::ACT_QUERY, 1024, 1100, 2048, 3000, 1, 1024, 1024, 0,
			0, 0, 0, 0, 0));
		rows.push_back(mk(svq_pkg::ACT_QUERY, 2048, 3000, 1024, 1100, 0, 0, 0, 1,
			1024, 1024, 0, 0, 0));
		rows.push_back(mk(svq_pkg::ACT_QUERY, CMAX, CMIN, CMIN, CMAX, 1, CMIN, CMIN, 1,
			CMAX, CMAX, 0, 0, 0));
		rows.push_back(mk(svq_pkg::ACT_QUERY, CMIN, CMAX, CMIN + 5, CMAX, 0, 0, 0, 0, 0, 0,
			0, 0, 0));
		rows.push_back(mk(svq_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, svq_pkg::ST_STORED, 0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		for (ph = 0; ph < 2; ph++) begin
			if (ph == 1)
				write_offset(16'hFFFF);
			foreach (rows[r]) begin
				if (rows[r].known && ph == 0) begin
					send(rows[r].it, $urandom_range(17));
					tail = last_pred;
					if (tail.st !== rows[r].st || tail.held !== rows[r].held) begin
						$display("%0t: directed row %0d expected %0d/%0d predicted %0d/%0d",
							$time, r, rows[r].st, rows[r].held, tail.st, tail.held);
						errors++;
					end
				end else
					send(rows[r].it, $urandom_range(17));
			end
			drain();
		end

		// fill to overflow, then query against a full table
		write_offset(16'd128);
		send(rows[1].it, 0);
		for (i = 0; i < NMAX + 2; i++) begin
			item_t it;
			it = rnd_item(100);
			it.act = svq_pkg::ACT_APPEND;
			send(it, (i % 20 < 10) ? 0 : $urandom_range(17));
		end
		for (i = 0; i < 6; i++) begin
			item_t it;
			it = rnd_item(0);
			it.act = svq_pkg::ACT_QUERY;
			send(it, $urandom_range(17));
		end
		drain();

		offsets[0] = 16'd0;
		offsets[1] = 16'hFFFF;
		offsets[2] = 16'($urandom_range(512));
		offsets[3] = 16'($urandom);
		for (ph = 0; ph < 8; ph++) begin
			write_offset(offsets[ph % 4]);
			for (k = 0; k < 90; k++)
				send(rnd_item(ph < 4 ? 45 : 60), (ph % 3 == 2) ? 0 : $urandom_range(17));
			drain();
		end

		@(negedge clk);
		start = 0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("segment_visibility_query_unit test passed");
		else
			$display("segment_visibility_query_unit test failed");
		$finish;
	end
endmodule

// File: filelist.f
rtl/svq_pkg.sv
rtl/svq_cross.sv
rtl/segment_visibility_query_unit.sv
sim/tb_top.sv
